// File: hdl/ecr_pkg.sv
// Shared types and constants for the elevator call register unit.
package ecr_pkg;

    typedef enum logic [2:0] {
        KIND_QUERY    = 3'd0,
        KIND_ADD_HALL = 3'd1,
        KIND_CLR_HALL = 3'd2,
        KIND_ADD_CAR  = 3'd3,
        KIND_CLR_CAR  = 3'd4,
        KIND_CLR_ALL  = 3'd5,
        KIND_POSITION = 3'd6
    } t_kind;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [4:0] floor;
        logic              call_direction;
        logic              travel_direction;
    } t_item;

    // Validity of the named floor, shared by the update and the report logic.
    typedef struct packed {
        logic hall_ok;
        logic car_ok;
        logic bad;
    } t_floor_check;

    typedef struct packed {
        logic [3:0] stop_floor;
        logic       between_floors;
        logic       hall_called;
        logic       car_called;
        logic       calls_above;
        logic       calls_below;
        logic       calls_elsewhere;
        logic       bad_request;
    } t_result;

    localparam logic [4:0]        FLOORS_RESET      = 5'd4;
    localparam logic [7:0]        MIN_FLOORS        = 8'd2;
    localparam logic [0:0]        REG_FLOORS_IN_USE = 1'b0;
    localparam logic signed [4:0] FLOOR_LEAVING     = -5'sd1;
    localparam logic              DIR_UP            = 1'b0;
    localparam logic              DIR_DOWN          = 1'b1;

endpackage

// File: hdl/elevator_call_register_unit.sv
// Top level of the elevator call register unit: handshakes, register port, stages.
// An accepted input item is held in the item register; its result is then registered in the result register.
// Throughput: one item per cycle; the item register feeds a single pass of update
// and lookup logic into the result register, which stalls only on output backpressure.
// Reset (synchronous, active low) clears all call bits, puts the car at floor 0,
// sets floors_in_use to 4 and empties both stages.
module elevator_call_register_unit
    import ecr_pkg::*;
#(
    parameter int MAX_FLOORS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input item channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_kind,
    input  logic signed [4:0] i_floor,
    input  logic              i_call_direction,
    input  logic              i_travel_direction,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [3:0]        o_stop_floor,
    output logic              o_between_floors,
    output logic              o_hall_called,
    output logic              o_car_called,
    output logic              o_calls_above,
    output logic              o_calls_below,
    output logic              o_calls_elsewhere,
    output logic              o_bad_request,
    // Register port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int FW = $clog2(MAX_FLOORS);
    localparam int PW = FW + 1;

    logic [4:0]  r_floors_in_use;
    logic        r_in_valid;
    t_item       r_item;
    logic        r_out_valid;
    t_result     r_result;

    logic        advance;
    logic        in_xfer;
    logic        cfg_write;
    logic [7:0]  cfg_floors;
    logic [7:0]  eff_floors;
    logic [FW-1:0] top;

    logic [MAX_FLOORS-1:0] up_calls;
    logic [MAX_FLOORS-1:0] down_calls;
    logic [MAX_FLOORS-1:0] car_calls;
    logic [PW-1:0]         position;
    t_floor_check          check;
    t_result               result;

    // Register port. A write lands in the access phase; pready never stalls.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floors_in_use <= FLOORS_RESET;
        end else if (cfg_write && (paddr[2] == REG_FLOORS_IN_USE)) begin
            r_floors_in_use <= pwdata[4:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FLOORS_IN_USE) begin
            prdata = 32'(r_floors_in_use);
        end
    end

    // The floor count in use is clamped to 2..MAX_FLOORS; the top floor is one less.
    always_comb begin
        cfg_floors = 8'(r_floors_in_use);
        if (cfg_floors < MIN_FLOORS) begin
            eff_floors = MIN_FLOORS;
        end else if (cfg_floors > 8'(MAX_FLOORS)) begin
            eff_floors = 8'(MAX_FLOORS);
        end else begin
            eff_floors = cfg_floors;
        end
        top = FW'(eff_floors - 8'd1);
    end

    // The item register moves into the result register whenever that one is
    // empty or being drained in the same cycle; the state update happens on
    // that same edge, so items are applied strictly in order.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= '{kind: i_kind, floor: i_floor, call_direction: i_call_direction,
                        travel_direction: i_travel_direction};
        end
        if (advance) begin
            r_result <= result;
        end
    end

    ecr_state #(
        .MAX_FLOORS (MAX_FLOORS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_item),
        .i_top        (top),
        .o_up_calls   (up_calls),
        .o_down_calls (down_calls),
        .o_car_calls  (car_calls),
        .o_position   (position),
        .o_check      (check)
    );

    ecr_status #(
        .MAX_FLOORS (MAX_FLOORS)
    ) u_status (
        .i_item       (r_item),
        .i_check      (check),
        .i_top        (top),
        .i_up_calls   (up_calls),
        .i_down_calls (down_calls),
        .i_car_calls  (car_calls),
        .i_position   (position),
        .o_result     (result)
    );

    assign o_out_valid       = r_out_valid;
    assign o_stop_floor      = r_result.stop_floor;
    assign o_between_floors  = r_result.between_floors;
    assign o_hall_called     = r_result.hall_called;
    assign o_car_called      = r_result.car_called;
    assign o_calls_above     = r_result.calls_above;
    assign o_calls_below     = r_result.calls_below;
    assign o_calls_elsewhere = r_result.calls_elsewhere;
    assign o_bad_request     = r_result.bad_request;

`ifndef NO_ASSERTIONS
    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A call above or below the car is never at the current stop.
    a_dir_implies_elsewhere: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_calls_above || o_calls_below) |-> o_calls_elsewhere)
        else $error("directional call not counted as elsewhere");

    // A rejected request names a floor invalid for the call it tried to change.
    a_bad_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_request |-> !(o_hall_called && o_car_called))
        else $error("rejected request reports both calls set");

    // The input side only stalls behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");
`endif

endmodule

// File: hdl/ecr_state.sv
// Call bit stores and half-floor position counter with their update logic.
module ecr_state
    import ecr_pkg::*;
#(
    parameter int MAX_FLOORS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  t_item                             i_item,
    input  logic [$clog2(MAX_FLOORS)-1:0]     i_top,
    output logic [MAX_FLOORS-1:0]             o_up_calls,
    output logic [MAX_FLOORS-1:0]             o_down_calls,
    output logic [MAX_FLOORS-1:0]             o_car_calls,
    output logic [$clog2(MAX_FLOORS):0]       o_position,
    output t_floor_check                      o_check
);

    localparam int FW = $clog2(MAX_FLOORS);
    localparam int PW = FW + 1;
    localparam int CW = (FW > 4) ? FW : 4;

    logic [MAX_FLOORS-1:0] r_up_calls, n_up_calls;
    logic [MAX_FLOORS-1:0] r_down_calls, n_down_calls;
    logic [MAX_FLOORS-1:0] r_car_calls, n_car_calls;
    logic [PW-1:0]         r_position, n_position;

    logic          floor_nonneg;
    logic [CW-1:0] floor_w;
    logic [CW-1:0] top_w;
    logic          up_ok;
    logic          down_ok;
    logic          car_ok;
    logic          hall_ok;
    logic [FW-1:0] idx;
    t_kind         kind;

    always_comb begin
        floor_nonneg = !i_item.floor[4];
        floor_w      = CW'(i_item.floor[3:0]);
        top_w        = CW'(i_top);
        up_ok        = floor_nonneg && (floor_w < top_w);
        down_ok      = floor_nonneg && (floor_w != '0) && (floor_w <= top_w);
        car_ok       = floor_nonneg && (floor_w <= top_w);
        hall_ok      = (i_item.call_direction == DIR_DOWN) ? down_ok : up_ok;
        idx          = FW'(i_item.floor[3:0]);
        kind         = t_kind'(i_item.kind);
    end

    always_comb begin
        n_up_calls   = r_up_calls;
        n_down_calls = r_down_calls;
        n_car_calls  = r_car_calls;
        n_position   = r_position;
        o_check      = '{hall_ok: hall_ok, car_ok: car_ok, bad: 1'b0};
        case (kind)
            KIND_ADD_HALL, KIND_CLR_HALL: begin
                if (hall_ok) begin
                    if (i_item.call_direction == DIR_DOWN) begin
                        n_down_calls[idx] = (kind == KIND_ADD_HALL);
                    end else begin
                        n_up_calls[idx] = (kind == KIND_ADD_HALL);
                    end
                end else begin
                    o_check.bad = 1'b1;
                end
            end
            KIND_ADD_CAR, KIND_CLR_CAR: begin
                if (car_ok) begin
                    n_car_calls[idx] = (kind == KIND_ADD_CAR);
                end else begin
                    o_check.bad = 1'b1;
                end
            end
            KIND_CLR_ALL: begin
                n_up_calls   = '0;
                n_down_calls = '0;
                n_car_calls  = '0;
            end
            KIND_POSITION: begin
                if (i_item.floor == FLOOR_LEAVING) begin
                    // Leaving only moves the car when it stands at a floor.
                    if (!r_position[0]) begin
                        if (i_item.travel_direction == DIR_UP) begin
                            if (r_position < {i_top, 1'b0}) begin
                                n_position = r_position + PW'(1);
                            end
                        end else if (r_position != '0) begin
                            n_position = r_position - PW'(1);
                        end
                    end
                end else if (car_ok) begin
                    n_position = {idx, 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_calls   <= '0;
            r_down_calls <= '0;
            r_car_calls  <= '0;
            r_position   <= '0;
        end else if (i_advance) begin
            r_up_calls   <= n_up_calls;
            r_down_calls <= n_down_calls;
            r_car_calls  <= n_car_calls;
            r_position   <= n_position;
        end
    end

    // The report covers the state after this item's update.
    assign o_up_calls   = n_up_calls;
    assign o_down_calls = n_down_calls;
    assign o_car_calls  = n_car_calls;
    assign o_position   = n_position;

endmodule

// File: hdl/ecr_status.sv
// Position report, per-floor call lookup and masked call reductions.
module ecr_status
    import ecr_pkg::*;
#(
    parameter int MAX_FLOORS = 16
) (
    input  t_item                           i_item,
    input  t_floor_check                    i_check,
    input  logic [$clog2(MAX_FLOORS)-1:0]   i_top,
    input  logic [MAX_FLOORS-1:0]           i_up_calls,
    input  logic [MAX_FLOORS-1:0]           i_down_calls,
    input  logic [MAX_FLOORS-1:0]           i_car_calls,
    input  logic [$clog2(MAX_FLOORS):0]     i_position,
    output t_result                         o_result
);

    localparam int FW = $clog2(MAX_FLOORS);
    localparam int PW = FW + 1;

    logic [FW-1:0] stop;
    logic [FW-1:0] idx;
    logic [FW-1:0] fi;
    logic          up_v;
    logic          down_v;
    logic          car_v;
    logic          any_v;
    logic          here;
    logic          above;
    logic          below;
    logic          elsewhere;

    always_comb begin
        stop      = i_position[PW-1:1];
        idx       = FW'(i_item.floor[3:0]);
        above     = 1'b0;
        below     = 1'b0;
        elsewhere = 1'b0;
        fi        = '0;
        up_v      = 1'b0;
        down_v    = 1'b0;
        car_v     = 1'b0;
        any_v     = 1'b0;
        here      = 1'b0;
        for (int f = 0; f < MAX_FLOORS; f++) begin
            fi     = FW'(f);
            up_v   = i_up_calls[f] && (fi < i_top);
            down_v = i_down_calls[f] && (fi != '0) && (fi <= i_top);
            car_v  = i_car_calls[f] && (fi <= i_top);
            any_v  = up_v || down_v || car_v;
            here   = !i_position[0] && (stop == fi);
            above  = above || (any_v && (fi > stop));
            below  = below || (any_v && ((fi < stop) || (i_position[0] && (fi == stop))));
            elsewhere = elsewhere
                || (up_v && !(here && (i_item.travel_direction == DIR_UP)))
                || (down_v && !(here && (i_item.travel_direction == DIR_DOWN)))
                || (car_v && !here);
        end
    end

    always_comb begin
        o_result.stop_floor      = 4'(stop);
        o_result.between_floors  = i_position[0];
        o_result.hall_called     = i_check.hall_ok
            && ((i_item.call_direction == DIR_DOWN) ? i_down_calls[idx] : i_up_calls[idx]);
        o_result.car_called      = i_check.car_ok && i_car_calls[idx];
        o_result.calls_above     = above;
        o_result.calls_below     = below;
        o_result.calls_elsewhere = elsewhere;
        o_result.bad_request     = i_check.bad;
    end

endmodule
